// ----- design/mu7d_pkg.sv -----
// ----------------------------------------------------------------------------
// mu7d_pkg
// Shared types, character codes and the base64 alphabet lookup for the
// modified UTF-7 to UTF-8 decoder.
// ----------------------------------------------------------------------------
package mu7d_pkg;

  // Decoder mode; the unused fourth code behaves as literal mode
  typedef enum logic [1:0] {
    MODE_LIT = 2'd0,
    MODE_AMP = 2'd1,
    MODE_RUN = 2'd2
  } mu7d_mode_t;

  // One queued burst: a literal byte or a code point to encode
  typedef struct packed {
    logic        is_lit;
    logic [31:0] value;
  } mu7d_entry_t;

  // Queue status toward the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } mu7d_qstat_t;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  // Base64 digit value; bit 6 set marks a byte outside the alphabet
  function automatic logic [6:0] mu7d_b64(input logic [7:0] b);
    logic [6:0] v;
    v = 7'd64;
    if (b >= 8'h41 && b <= 8'h5A) v = 7'(b - 8'h41);
    else if (b >= 8'h61 && b <= 8'h7A) v = 7'(b - 8'h61 + 8'd26);
    else if (b >= 8'h30 && b <= 8'h39) v = 7'(b - 8'h30 + 8'd52);
    else if (b == CH_PLUS) v = 7'd62;
    else if (b == CH_COMMA) v = 7'd63;
    return v;
  endfunction

endpackage

// ----- design/mu7d_front.sv -----
// ----------------------------------------------------------------------------
// mu7d_front
// Accepts source bytes, tracks literal/ampersand/base64 mode, gathers base64
// bits into UTF-16 units, joins surrogates and queues one burst per output.
// ----------------------------------------------------------------------------
module mu7d_front import mu7d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_string,
  output logic        push,
  output mu7d_entry_t push_data
);

  mu7d_mode_t  mode_r, mode_nxt;
  logic [21:0] buf_r, buf_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] held_r, held_nxt;

  logic [21:0] buf_base, buf_sh;
  logic [4:0]  cnt_base, cnt_add, cnt_sub;
  logic [31:0] held_base, held_hi, held_lo, held_unit;
  logic [6:0]  b64_v;
  logic [15:0] unit;
  logic        is_b64, is_hi, is_lo, unit_full, do_run, is_dash, is_amp;
  logic        c_amp_dash, c_digit, c_run_dash, c_literal;

  // Datapath: digit decode, bit gathering and surrogate arithmetic
  always_comb begin
    b64_v     = mu7d_b64(in_byte);
    is_b64    = ~b64_v[6];
    is_dash   = (in_byte == CH_DASH);
    is_amp    = (in_byte == CH_AMP);
    buf_base  = (mode_r == MODE_AMP) ? '0 : buf_r;
    cnt_base  = (mode_r == MODE_AMP) ? '0 : cnt_r;
    held_base = (mode_r == MODE_AMP) ? '0 : held_r;
    buf_sh    = {buf_base[15:0], b64_v[5:0]};
    cnt_add   = cnt_base + 5'd6;
    unit_full = (cnt_add >= 5'd16);
    cnt_sub   = cnt_add - 5'd16;
    unit      = 16'(buf_sh >> cnt_sub);
    is_hi     = (unit[15:10] == 6'b110110);
    is_lo     = (unit[15:10] == 6'b110111);
    held_hi   = {12'd0, unit[9:0], 10'd0};
    // unit - DC00 + 10000 folds into one add
    held_lo   = held_base + {15'd0, 1'b1, 6'd0, unit[9:0]};
    held_unit = is_lo ? held_lo : {16'd0, unit};
    do_run    = (mode_r == MODE_RUN) || ((mode_r == MODE_AMP) && !is_dash);
    c_amp_dash = (mode_r == MODE_AMP) && is_dash;
    c_digit    = do_run && is_b64;
    c_run_dash = do_run && !is_b64 && is_dash;
    c_literal  = !c_amp_dash && !c_digit && !c_run_dash;
  end

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    held_nxt = held_r;
    if (accept) begin
      if (c_amp_dash) begin
        mode_nxt = MODE_LIT;
      end else if (c_digit) begin
        mode_nxt = MODE_RUN;
        buf_nxt  = buf_sh;
        cnt_nxt  = unit_full ? cnt_sub : cnt_add;
        held_nxt = !unit_full ? held_base : (is_hi ? held_hi : held_unit);
      end else begin
        mode_nxt = (c_literal && is_amp) ? MODE_AMP : MODE_LIT;
        buf_nxt  = buf_base;
        cnt_nxt  = cnt_base;
        held_nxt = held_base;
      end
      // End of string drops everything pending
      if (in_end_of_string) begin
        mode_nxt = MODE_LIT;
        buf_nxt  = '0;
        cnt_nxt  = '0;
        held_nxt = '0;
      end
    end
  end

  // Outputs: queue a burst for every byte that yields output
  always_comb begin
    push             = 1'b0;
    push_data.is_lit = 1'b1;
    push_data.value  = {24'd0, in_byte};
    if (c_amp_dash) begin
      push            = accept;
      push_data.value = {24'd0, CH_AMP};
    end else if (c_digit) begin
      push             = accept && unit_full && !is_hi;
      push_data.is_lit = 1'b0;
      push_data.value  = held_unit;
    end else if (c_literal) begin
      push = accept && !is_amp;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LIT;
      buf_r  <= '0;
      cnt_r  <= '0;
      held_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ----- design/mu7d_queue.sv -----
// ----------------------------------------------------------------------------
// mu7d_queue
// Short first-in first-out queue of bursts between the front and the back.
// ----------------------------------------------------------------------------
module mu7d_queue import mu7d_pkg::*; #(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mu7d_entry_t push_data,
  input  logic        pop,
  output mu7d_entry_t head,
  output mu7d_qstat_t stat
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

  mu7d_entry_t   slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write the slot
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- design/mu7d_back.sv -----
// ----------------------------------------------------------------------------
// mu7d_back
// Encodes the queue head as UTF-8 and drains it one byte per beat through
// the output register.
// ----------------------------------------------------------------------------
module mu7d_back import mu7d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mu7d_entry_t head,
  input  mu7d_qstat_t stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_burst
);

  logic [1:0]       idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r;
  logic             last_r;
  logic [1:0]       len_m1;
  logic [3:0][7:0]  enc;
  logic [31:0]      cp;
  logic             load, last;

  // Encode the head entry
  always_comb begin
    cp     = head.value;
    len_m1 = 2'd0;
    enc    = '0;
    if (head.is_lit || cp[31:7] == '0) begin
      enc[0] = cp[7:0];
    end else if (cp[31:11] == '0) begin
      len_m1 = 2'd1;
      enc[0] = UTF8_LEAD2 | cp[13:6];
      enc[1] = UTF8_CONT | {2'b00, cp[5:0]};
    end else if (cp[31:16] == '0) begin
      len_m1 = 2'd2;
      enc[0] = UTF8_LEAD3 | cp[19:12];
      enc[1] = UTF8_CONT | {2'b00, cp[11:6]};
      enc[2] = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      len_m1 = 2'd3;
      enc[0] = UTF8_LEAD4 | cp[25:18];
      enc[1] = UTF8_CONT | {2'b00, cp[17:12]};
      enc[2] = UTF8_CONT | {2'b00, cp[11:6]};
      enc[3] = UTF8_CONT | {2'b00, cp[5:0]};
    end
  end

  // Load the output register whenever it is free or being taken
  always_comb begin
    load      = !stat.empty && (!valid_r || out_ready);
    last      = (idx_r == len_m1);
    pop       = load && last;
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload holds while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= enc[idx_r];
      last_r <= last;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_last_of_burst = last_r;

endmodule

// ----- design/modified_utf7_to_utf8_decoder_top.sv -----
// ----------------------------------------------------------------------------
// modified_utf7_to_utf8_decoder_top
// IMAP modified UTF-7 to UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one source byte per beat with
// in_end_of_string set on the last byte of a string. Output channel:
// out_valid/out_ready carry one UTF-8 byte per beat; out_last_of_burst marks
// the last byte produced by one source byte. Source bytes that produce
// nothing (an '&', base64 digits that do not finish a unit, a high surrogate,
// a closing '-') yield no output beat.
// Throughput: one source byte per cycle in while the queue has room, one
// UTF-8 byte per cycle out while out_ready is high. A 2, 3 or 4 byte
// sequence drains byte by byte through the output register; the front keeps
// accepting until the burst queue (QUEUE_DEPTH entries) fills.
// Reset (rst_n low, synchronous) returns to literal mode, clears the bit
// buffer and the held code point, and empties the queue and output register.
// When the receiver stalls, the output byte holds, the queue fills, and
// in_ready drops once it is full.
// ----------------------------------------------------------------------------
module modified_utf7_to_utf8_decoder_top import mu7d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_burst
);

  mu7d_entry_t push_data, head;
  mu7d_qstat_t q_stat;
  logic        push, pop, accept;

  // Take a beat whenever the queue has room
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  mu7d_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .push             (push),
    .push_data        (push_data)
  );

  mu7d_queue #(
    .QDEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  mu7d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .stat              (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_burst (out_last_of_burst)
  );

`ifndef SYNTHESIS
  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("burst queue overflow");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("burst queue underflow");

  // A burst drains without gaps once its first beat is taken
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_burst) |=> out_valid)
    else $error("gap inside a UTF-8 burst");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test for the modified UTF-7 to UTF-8 decoder. Source bytes go in
// through a queue-fed driver, and a clocked monitor checks each UTF-8 byte
// against a cycle-free model of the decoder. Three traffic phases vary sender
// and receiver gaps. One long receiver stall fills the burst queue.
// ----------------------------------------------------------------------------
module tb_top;
  import mu7d_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 150;
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_DIGIT_0 = "0";
  localparam logic [7:0] CH_SLASH   = "/";

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } src_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_burst;

  // Source beats waiting for the driver, and UTF-8 beats still owed
  src_beat_t  pending_src[$];
  utf8_beat_t utf8_owed[$];
  logic [15:0] unit_q[$];
  int src_pushed = 0;
  int src_taken  = 0;
  int err_cnt    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int test_phase = 0;

  // Decoder model state
  mu7d_mode_t  dec_mode = MODE_LIT;
  logic [21:0] bit_acc = '0;
  logic [4:0]  bit_cnt = '0;
  logic [31:0] code_point = '0;

  modified_utf7_to_utf8_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_burst(out_last_of_burst)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- alphabet
  function automatic int b64_index(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd25) return int'(c - CH_UPPER_A);
    if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd25) return int'(c - CH_LOWER_A) + 26;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_0 + 8'd9) return int'(c - CH_DIGIT_0) + 52;
    if (c == CH_PLUS) return 62;
    if (c == CH_COMMA) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return CH_UPPER_A + 8'(v);
    if (v < 6'd52) return CH_LOWER_A + 8'(v - 6'd26);
    if (v < 6'd62) return CH_DIGIT_0 + 8'(v - 6'd52);
    return (v == 6'd62) ? CH_PLUS : CH_COMMA;
  endfunction

  // ---------------------------------------------------------------- model
  function automatic void owe_byte(input logic [7:0] v);
    utf8_owed.push_back('{data: v, last: 1'b0});
  endfunction

  function automatic void owe_code_point(input logic [31:0] cp);
    if (cp <= 32'h7F) begin
      owe_byte(cp[7:0]);
    end else if (cp <= 32'h7FF) begin
      owe_byte(UTF8_LEAD2 | 8'(cp >> 6));
      owe_byte(UTF8_CONT | {2'b00, cp[5:0]});
    end else if (cp <= 32'hFFFF) begin
      owe_byte(UTF8_LEAD3 | 8'(cp >> 12));
      owe_byte(UTF8_CONT | {2'b00, cp[11:6]});
      owe_byte(UTF8_CONT | {2'b00, cp[5:0]});
    end else begin
      // lead byte keeps only its low eight bits
      owe_byte(8'({24'd0, UTF8_LEAD4} | (cp >> 18)));
      owe_byte(UTF8_CONT | {2'b00, cp[17:12]});
      owe_byte(UTF8_CONT | {2'b00, cp[11:6]});
      owe_byte(UTF8_CONT | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    if (b == CH_AMP) begin
      dec_mode = MODE_AMP;
    end else begin
      dec_mode = MODE_LIT;
      owe_byte(b);
    end
  endfunction

  function automatic void shifted_byte(input logic [7:0] b);
    int          digit;
    logic [15:0] unit;
    digit = b64_index(b);
    if (digit < 0) begin
      // close the run: swallow a dash, treat anything else as plain text
      if (b == CH_DASH) dec_mode = MODE_LIT;
      else plain_byte(b);
    end else begin
      bit_acc = {bit_acc[15:0], 6'(digit)};
      bit_cnt = bit_cnt + 5'd6;
      if (bit_cnt >= 5'd16) begin
        bit_cnt = bit_cnt - 5'd16;
        unit = 16'(bit_acc >> bit_cnt);
        if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
          code_point = (32'(unit) - 32'hD800) << 10;
        end else begin
          if (unit >= 16'hDC00 && unit <= 16'hDFFF)
            code_point = code_point + 32'(unit) - 32'hDC00 + 32'h10000;
          else
            code_point = 32'(unit);
          owe_code_point(code_point);
        end
      end
    end
  endfunction

  function automatic void decode_src_byte(input logic [7:0] b, input logic eos);
    int owed_before;
    owed_before = utf8_owed.size();
    case (dec_mode)
      MODE_AMP: begin
        if (b == CH_DASH) begin
          dec_mode = MODE_LIT;
          owe_byte(CH_AMP);
        end else begin
          dec_mode   = MODE_RUN;
          bit_acc    = '0;
          bit_cnt    = '0;
          code_point = '0;
          shifted_byte(b);
        end
      end
      MODE_RUN: shifted_byte(b);
      default:  plain_byte(b);
    endcase
    if (eos) begin
      dec_mode   = MODE_LIT;
      bit_acc    = '0;
      bit_cnt    = '0;
      code_point = '0;
    end
    if (utf8_owed.size() > owed_before) utf8_owed[utf8_owed.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void push_src(input logic [7:0] b, input logic eos);
    pending_src.push_back('{data: b, eos: eos});
    src_pushed++;
  endfunction

  // Encode unit_q as base64 digits, padding the tail with zero bits
  function automatic void push_b64_units(input logic eos_last);
    logic [31:0] acc;
    int          nbits;
    acc   = '0;
    nbits = 0;
    foreach (unit_q[i]) begin
      acc   = (acc << 16) | 32'(unit_q[i]);
      nbits += 16;
      while (nbits >= 6) begin
        nbits -= 6;
        push_src(b64_char(6'(acc >> nbits)), 1'b0);
      end
      acc &= (32'd1 << nbits) - 32'd1;
    end
    if (nbits > 0) push_src(b64_char(6'(acc << (6 - nbits))), 1'b0);
    unit_q.delete();
    if (eos_last && pending_src.size() > 0) pending_src[pending_src.size() - 1].eos = 1'b1;
  endfunction

  function automatic logic [7:0] rand_non_b64();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (b64_index(c) >= 0);
    return c;
  endfunction

  function automatic void add_code_point();
    case ($urandom_range(0, 6))
      0: unit_q.push_back(16'($urandom_range(0, 'h7F)));
      1: unit_q.push_back(16'($urandom_range('h80, 'h7FF)));
      2: begin
        if ($urandom_range(0, 1) == 0) unit_q.push_back(16'($urandom_range('h800, 'hD7FF)));
        else unit_q.push_back(16'($urandom_range('hE000, 'hFFFF)));
      end
      3: begin
        unit_q.push_back(16'($urandom_range('hD800, 'hDBFF)));
        unit_q.push_back(16'($urandom_range('hDC00, 'hDFFF)));
      end
      4: unit_q.push_back(16'($urandom_range('hDC00, 'hDFFF)));
      5: unit_q.push_back(16'($urandom_range('hD800, 'hDBFF)));
      default: unit_q.push_back(16'($urandom_range(0, 'hFFFF)));
    endcase
  endfunction

  function automatic void add_random_stream(input int n_items);
    int         target;
    int         kind;
    logic [7:0] c;
    target = src_pushed + n_items;
    while (src_pushed < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // well-formed shifted run with random content, closed by a byte or end of string
        push_src(CH_AMP, 1'b0);
        repeat ($urandom_range(1, 4)) add_code_point();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            push_b64_units(1'b0);
            push_src(CH_DASH, 1'b0);
          end
          5: begin
            push_b64_units(1'b0);
            push_src(CH_AMP, 1'b0);
          end
          6, 7: begin
            push_b64_units(1'b0);
            push_src(rand_non_b64(), $urandom_range(0, 3) == 0);
          end
          default: push_b64_units(1'b1);
        endcase
      end else if (kind < 80) begin
        // plain noise, with ampersands and dashes mixed in
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 7))
            0:       c = CH_AMP;
            1:       c = CH_DASH;
            default: c = 8'($urandom_range(0, 255));
          endcase
          push_src(c, $urandom_range(0, 7) == 0);
        end
      end else begin
        // broken run: a few digits cut short by any byte or end of string
        push_src(CH_AMP, 1'b0);
        repeat ($urandom_range(0, 5))
          push_src(b64_char(6'($urandom_range(0, 63))), $urandom_range(0, 9) == 0);
        push_src(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
  endfunction

  // ---------------------------------------------------------------- driver
  src_beat_t next_src;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_src_byte(in_byte, in_end_of_string);
        src_taken++;
      end
      // load a new beat once the slot is free, or idle
      if (!in_valid || in_ready) begin
        if (pending_src.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_src = pending_src.pop_front();
          in_valid         <= 1'b1;
          in_byte          <= next_src.data;
          in_end_of_string <= next_src.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  utf8_beat_t want;
  int hold_left = 0;
  bit held_once = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (utf8_owed.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual byte %h last %b",
                   $time, out_byte, out_last_of_burst);
          err_cnt++;
        end else begin
          want = utf8_owed.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte mismatch, expected %h actual %h",
                     $time, want.data, out_byte);
            err_cnt++;
          end
          if (out_last_of_burst !== want.last) begin
            $display("%0t: out_last_of_burst mismatch, expected %b actual %b",
                     $time, want.last, out_last_of_burst);
            err_cnt++;
          end
        end
      end
      // hold off once for a long stretch in the last phase, else random gaps
      if (test_phase == 3 && !held_once) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  task automatic wait_drained();
    do @(posedge clk); while (src_taken != src_pushed || utf8_owed.size() != 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender gaps light, receiver gaps heavy; directed beats first
    send_idle_pct = 24;
    recv_idle_pct = 61;
    test_phase    = 1;
    push_src(8'h00, 1'b0);
    push_src(8'hFF, 1'b0);
    push_src(CH_AMP, 1'b0);
    push_src(CH_DASH, 1'b0);
    // two-byte, three-byte and the highest surrogate pair; close with a new '&'
    push_src(CH_AMP, 1'b0);
    unit_q = '{16'h07FF, 16'hFFFF, 16'hDBFF, 16'hDFFF};
    push_b64_units(1'b0);
    push_src(CH_AMP, 1'b0);
    // lone low surrogate, string ends with bits left over
    unit_q = '{16'hDC00};
    push_b64_units(1'b1);
    // pending ampersand dropped at end of string
    push_src(CH_AMP, 1'b1);
    // run opened and closed at once by a plain byte
    push_src(CH_AMP, 1'b0);
    push_src(CH_SLASH, 1'b0);
    add_random_stream(45);
    wait_drained();

    // Phase 2: heavy sender gaps, light receiver gaps
    send_idle_pct = 61;
    recv_idle_pct = 24;
    test_phase    = 2;
    add_random_stream(45);
    wait_drained();

    // Phase 3: no gaps; long receiver stall, then a run of lone low surrogates
    // that pushes the held value past the 21-bit range
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_phase    = 3;
    push_src(CH_AMP, 1'b0);
    unit_q.push_back(16'hDBFF);
    repeat (24) unit_q.push_back(16'hDFFF);
    push_b64_units(1'b0);
    push_src(CH_DASH, 1'b0);
    add_random_stream(15);
    wait_drained();

    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
